### hw/rtl/ubh_pkg.sv
`default_nettype none
package ubh_pkg;

  localparam int MAX_BINS = 256;
  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int NBIN_W   = 9;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 32;
  // dividend of every division: value times bin count or bin index, plus rounding bias
  localparam int NUM_W    = DATA_W + BIN_W;
  localparam int DCNT_W   = $clog2(NUM_W + 1);
  localparam int QPTR_W   = 1;
  localparam int QDEPTH   = 2 ** QPTR_W;
  localparam int ADDR_W   = 4;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_RANGE_LOW  = 2'd0;
  localparam reg_idx_t REG_RANGE_HIGH = 2'd1;
  localparam reg_idx_t REG_BINS       = 2'd2;

  localparam logic signed [DATA_W-1:0] RST_RANGE_LOW  = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_RANGE_HIGH = 32'sd65536;
  localparam logic [NBIN_W-1:0]        RST_BINS       = 9'd256;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] sample_value;
    logic [BIN_W-1:0]         bin_select;
  } in_item_t;

  typedef struct packed {
    logic                     sample_counted;
    logic [BIN_W-1:0]         bin_number;
    logic [COUNT_W-1:0]       bin_tally;
    logic signed [DATA_W-1:0] bin_center;
    logic signed [DATA_W-1:0] bin_lower;
    logic signed [DATA_W-1:0] bin_upper;
    logic [COUNT_W-1:0]       total_samples;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_low;
    logic signed [DATA_W-1:0] range_high;
    logic [NBIN_W-1:0]        n;     // bins in use, clamped to 1..MAX_BINS
    logic [DATA_W-1:0]        span;  // high - low, zero for an empty range
  } cfg_view_t;

  typedef enum logic [1:0] {
    OP_MISS,
    OP_ADD,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] delta;  // sample - range_low
    logic [BIN_W-1:0]  bin;    // clamped bin for a read
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
    job_t head;
  } q_stat_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIN,
    ST_LO_GO,
    ST_LO,
    ST_HI_GO,
    ST_HI,
    ST_EMIT
  } bstate_t;

endpackage
`default_nettype wire

### hw/rtl/uniform_bin_histogram_core.sv
`default_nettype none
// Uniform-bin histogram over signed Q16.16 samples. An item is taken when
// start is high and busy is low; busy rises only while the two-item queue
// between the classifier and the counter engine is full. Every item yields
// one result, shown on out_item for exactly one cycle with out_valid high;
// the receiver must take it then. Results come in item order. Items leave the
// queue one at a time: a sample outside the range needs no division, a read
// needs two and a counted sample three, all on the shared serial divider
// (bin index, lower edge, upper edge). Bin counters and the total clear at
// reset with no sweep; configuration writes keep the counters.
module uniform_bin_histogram_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ubh_pkg::in_item_t          in_item,
  output logic                       out_valid,
  output ubh_pkg::out_item_t         out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ubh_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ubh_pkg::*;

  cfg_view_t cfg;
  push_t     push;
  q_stat_t   q_stat;
  logic      q_pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  ubh_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ubh_front u_front (
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .push    (push)
  );

  ubh_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (q_pop),
    .q_stat (q_stat)
  );

  ubh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ubh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### hw/rtl/ubh_regs.sv
`default_nettype none
module ubh_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ubh_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ubh_pkg::cfg_view_t         cfg
);
  import ubh_pkg::*;

  logic signed [DATA_W-1:0] low_r;
  logic signed [DATA_W-1:0] high_r;
  logic [NBIN_W-1:0]        bins_r;
  reg_idx_t                 idx;
  logic                     wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= RST_RANGE_LOW;
      high_r <= RST_RANGE_HIGH;
      bins_r <= RST_BINS;
    end else if (wr_en) begin
      unique case (idx)
        REG_RANGE_LOW:  low_r  <= pwdata;
        REG_RANGE_HIGH: high_r <= pwdata;
        REG_BINS:       bins_r <= pwdata[NBIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RANGE_LOW:  prdata = low_r;
      REG_RANGE_HIGH: prdata = high_r;
      REG_BINS:       prdata = 32'(bins_r);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.range_low  = low_r;
    cfg.range_high = high_r;
    if (bins_r == '0) begin
      cfg.n = NBIN_W'(1);
    end else if (bins_r > NBIN_W'(MAX_BINS)) begin
      cfg.n = NBIN_W'(MAX_BINS);
    end else begin
      cfg.n = bins_r;
    end
    cfg.span = (high_r > low_r) ? DATA_W'(high_r - low_r) : '0;
  end

endmodule
`default_nettype wire

### hw/rtl/ubh_front.sv
`default_nettype none
module ubh_front (
  input  logic               start,
  output logic               busy,
  input  ubh_pkg::in_item_t  in_item,
  input  ubh_pkg::cfg_view_t cfg,
  input  ubh_pkg::q_stat_t   q_stat,
  output ubh_pkg::push_t     push
);
  import ubh_pkg::*;

  logic in_range;

  // an empty range fails one of the two compares
  assign in_range = ($signed(in_item.sample_value) >= $signed(cfg.range_low)) &&
                    ($signed(in_item.sample_value) <  $signed(cfg.range_high));

  assign busy       = q_stat.full;
  assign push.valid = start & ~q_stat.full;

  always_comb begin
    if (in_item.req_type) begin
      push.job.op = OP_READ;
    end else if (in_range) begin
      push.job.op = OP_ADD;
    end else begin
      push.job.op = OP_MISS;
    end
    push.job.delta = DATA_W'(in_item.sample_value - cfg.range_low);
    push.job.bin   = (NBIN_W'(in_item.bin_select) >= cfg.n) ? BIN_W'(cfg.n - 1'b1)
                                                            : in_item.bin_select;
  end

endmodule
`default_nettype wire

### hw/rtl/ubh_queue.sv
`default_nettype none
module ubh_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  ubh_pkg::push_t   push,
  input  logic             pop,
  output ubh_pkg::q_stat_t q_stat
);
  import ubh_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign q_stat.head  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push.valid) wptr_r <= wptr_r + 1'b1;
      if (pop)        rptr_r <= rptr_r + 1'b1;
      if (push.valid && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push.valid) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) slot_r[wptr_r] <= push.job;
  end

endmodule
`default_nettype wire

### hw/rtl/ubh_div.sv
`default_nettype none
module ubh_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ubh_pkg::div_req_t req,
  output ubh_pkg::div_rsp_t rsp
);
  import ubh_pkg::*;

  // restoring divider, one quotient bit per cycle; dividend shifts out at the
  // top while quotient bits shift in at the bottom
  logic [NUM_W-1:0]  nq_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;

  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [DATA_W-1:0] rem_nxt;

  assign rem_sh  = {rem_r, nq_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? DATA_W'(rem_sh - {1'b0, den_r}) : rem_sh[DATA_W-1:0];

  assign rsp.done = done_r;
  assign rsp.quo  = nq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= DCNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      nq_r  <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (run_r) begin
      nq_r  <= {nq_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ubh_back.sv
`default_nettype none
module ubh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ubh_pkg::cfg_view_t cfg,
  input  ubh_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output ubh_pkg::div_req_t  div_req,
  input  ubh_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  output ubh_pkg::out_item_t out_item
);
  import ubh_pkg::*;

  bstate_t            state_r;
  bstate_t            state_nxt;
  op_t                op_r;
  logic [BIN_W-1:0]   bin_r;
  logic [DATA_W-1:0]  lo_r;
  logic [DATA_W-1:0]  hi_r;
  logic [COUNT_W-1:0] tally_r;
  logic [COUNT_W-1:0] total_r;
  logic [MAX_BINS-1:0] valid_r;
  logic [COUNT_W-1:0] cnt_mem [MAX_BINS];
  logic [COUNT_W-1:0] mem_q_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [DATA_W-1:0]  mul_a;
  logic [NBIN_W-1:0]  mul_b;
  logic [NBIN_W-1:0]  bias;
  logic [DATA_W+NBIN_W-1:0] prod;
  logic               mem_rd;
  logic               lo_ld;
  logic               hi_ld;
  logic               bin_ld;
  logic               emit;
  logic               emit_miss;
  logic               is_add;
  logic [BIN_W-1:0]   bin_hit;
  logic [COUNT_W-1:0] cnt_now;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] total_inc;
  logic [DATA_W-1:0]  edge_val;
  logic [DATA_W-1:0]  half_w;

  // one shared 32x9 multiplier feeds the divider's dividend register
  assign prod        = mul_a * mul_b;
  assign div_req.num = NUM_W'(prod) + NUM_W'(bias);

  assign is_add    = (op_r == OP_ADD);
  assign bin_hit   = (div_rsp.quo >= NUM_W'(cfg.n)) ? BIN_W'(cfg.n - 1'b1)
                                                    : div_rsp.quo[BIN_W-1:0];
  assign cnt_now   = valid_r[bin_r] ? mem_q_r : '0;
  assign cnt_inc   = (cnt_now == {COUNT_W{1'b1}}) ? cnt_now : cnt_now + 1'b1;
  assign total_inc = (total_r == {COUNT_W{1'b1}}) ? total_r : total_r + 1'b1;
  assign edge_val  = DATA_W'(cfg.range_low) + div_rsp.quo[DATA_W-1:0];
  assign half_w    = (hi_r - lo_r) >> 1;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.den   = cfg.span;
    mul_a         = q_stat.head.delta;
    mul_b         = cfg.n;
    bias          = '0;
    mem_rd        = 1'b0;
    lo_ld         = 1'b0;
    hi_ld         = 1'b0;
    bin_ld        = 1'b0;
    emit          = 1'b0;
    emit_miss     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          unique case (q_stat.head.op)
            OP_ADD: begin
              div_req.start = 1'b1;
              state_nxt     = ST_BIN;
            end
            OP_READ: state_nxt = ST_LO_GO;
            default: emit_miss = 1'b1;
          endcase
        end
      end
      ST_BIN: begin
        if (div_rsp.done) begin
          bin_ld    = 1'b1;
          state_nxt = ST_LO_GO;
        end
      end
      ST_LO_GO: begin
        // lower edge: ceil(bin * span / n)
        div_req.start = 1'b1;
        div_req.den   = DATA_W'(cfg.n);
        mul_a         = cfg.span;
        mul_b         = NBIN_W'(bin_r);
        bias          = cfg.n - 1'b1;
        mem_rd        = 1'b1;
        state_nxt     = ST_LO;
      end
      ST_LO: begin
        if (div_rsp.done) begin
          lo_ld     = 1'b1;
          state_nxt = ST_HI_GO;
        end
      end
      ST_HI_GO: begin
        div_req.start = 1'b1;
        div_req.den   = DATA_W'(cfg.n);
        mul_a         = cfg.span;
        mul_b         = NBIN_W'(bin_r) + 1'b1;
        bias          = cfg.n - 1'b1;
        state_nxt     = ST_HI;
      end
      ST_HI: begin
        if (div_rsp.done) begin
          hi_ld     = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit | emit_miss;
      if (lo_ld && is_add) begin
        valid_r[bin_r] <= 1'b1;
        total_r        <= total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r  <= q_stat.head.op;
      bin_r <= q_stat.head.bin;
    end
    if (bin_ld) bin_r <= bin_hit;
    if (mem_rd) mem_q_r <= cnt_mem[bin_r];
    if (lo_ld) begin
      lo_r    <= edge_val;
      tally_r <= is_add ? cnt_inc : cnt_now;
      if (is_add) cnt_mem[bin_r] <= cnt_inc;
    end
    if (hi_ld) hi_r <= edge_val;
    if (emit_miss) begin
      out_item_r <= '{sample_counted: 1'b0, bin_number: '0, bin_tally: '0,
                      bin_center: '0, bin_lower: '0, bin_upper: '0,
                      total_samples: total_r};
    end else if (emit) begin
      out_item_r <= '{sample_counted: is_add, bin_number: bin_r, bin_tally: tally_r,
                      bin_center: lo_r + half_w, bin_lower: lo_r, bin_upper: hi_r,
                      total_samples: total_r};
    end
  end

endmodule
`default_nettype wire
